/* hdl/okie_pkg.sv */
`timescale 1ns / 1ps
package okie_pkg;

  typedef enum logic [1:0] {
    KIND_UASC  = 2'd0,
    KIND_UDESC = 2'd1,
    KIND_SASC  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [7:0]  ZERO_PREFIX = 8'h88;
  localparam logic [7:0]  LONG_BASE   = 8'hF5;
  localparam logic [63:0] SMALL_LIMIT = 64'd109;

  localparam int QUEUE_DEPTH = 2;

  // One classified request: the prefix byte, the number of payload bytes that
  // follow it (zero for a one-byte key) and the payload, left-aligned so that
  // the first byte to send sits in bits 63:56.
  typedef struct packed {
    logic [7:0]  prefix;
    logic [3:0]  nbytes;
    logic [63:0] payload;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  // Number of significant bytes of v, at least one.
  function automatic logic [3:0] sig_bytes(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (|(v >> (8 * i))) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Smallest n with m < 2^(8n)-1, where m is the complement of a negative value.
  function automatic logic [3:0] neg_bytes(input logic [63:0] m);
    logic [3:0]  n;
    logic [63:0] lim;
    n = 4'd8;
    for (int i = 7; i >= 1; i--) begin
      lim = (64'd1 << (8 * i)) - 64'd1;
      if (m < lim) n = 4'(i);
    end
    return n;
  endfunction

endpackage

/* hdl/okie_ifs.sv */
`timescale 1ns / 1ps
interface okie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface okie_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* hdl/okie_front.sv */
`timescale 1ns / 1ps
module okie_front (
  input  logic           clk,
  input  logic           rst_n,
  okie_in_if.sink        in_chan,
  input  logic           q_ready,
  output logic           f_valid,
  output okie_pkg::job_t f_job
);

  logic           f_valid_r, f_valid_nxt;
  okie_pkg::job_t f_job_r, f_job_nxt;
  okie_pkg::job_t cls_job;
  okie_pkg::kind_t kind;
  logic [63:0]    v;
  logic [63:0]    raw_pay;
  logic [3:0]     n;
  logic [3:0]     gap;
  logic [5:0]     shamt;
  logic           drop;
  logic           accept;

  // Classification of the request on the input channel.
  always_comb begin
    kind    = okie_pkg::kind_t'(in_chan.kind);
    v       = in_chan.value;
    raw_pay = v;
    n       = 4'd0;
    drop    = 1'b0;
    cls_job.prefix = okie_pkg::ZERO_PREFIX;
    case (kind)
      okie_pkg::KIND_UASC, okie_pkg::KIND_SASC: begin
        if (kind == okie_pkg::KIND_SASC && v[63]) begin
          n              = okie_pkg::neg_bytes(~v);
          cls_job.prefix = okie_pkg::ZERO_PREFIX - {4'd0, n};
        end else if (v <= okie_pkg::SMALL_LIMIT) begin
          cls_job.prefix = okie_pkg::ZERO_PREFIX + v[7:0];
        end else begin
          n              = okie_pkg::sig_bytes(v);
          cls_job.prefix = okie_pkg::LONG_BASE + {4'd0, n};
        end
      end
      okie_pkg::KIND_UDESC: begin
        if (v != 64'd0) begin
          n              = okie_pkg::sig_bytes(v);
          cls_job.prefix = okie_pkg::ZERO_PREFIX - {4'd0, n};
          raw_pay        = ~v;
        end
      end
      default: drop = 1'b1;
    endcase
    gap             = 4'd8 - n;
    shamt           = {gap[2:0], 3'b000};
    cls_job.nbytes  = n;
    cls_job.payload = raw_pay << shamt;
  end

  assign in_chan.ready = !f_valid_r || q_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    f_valid_nxt = f_valid_r;
    f_job_nxt   = f_job_r;
    if (q_ready) f_valid_nxt = 1'b0;
    if (accept && !drop) begin
      f_valid_nxt = 1'b1;
      f_job_nxt   = cls_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_job_r <= f_job_nxt;
  end

  assign f_valid = f_valid_r;
  assign f_job   = f_job_r;

endmodule

/* hdl/okie_queue.sv */
`timescale 1ns / 1ps
module okie_queue #(
  parameter int DEPTH = okie_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  okie_pkg::job_t    push_job,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output okie_pkg::job_t    pop_job,
  output okie_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  okie_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

/* hdl/okie_back.sv */
`timescale 1ns / 1ps
module okie_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  okie_pkg::job_t       q_job,
  output logic                 q_pop,
  okie_out_if.source           out_chan,
  output okie_pkg::back_stat_t stat
);

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [63:0] pay_r, pay_nxt;
  logic [3:0]  left_r, left_nxt;
  logic        advance;

  assign advance = !out_valid_r || out_chan.ready;

  // Payload bytes take priority; a new request is popped only once the
  // current one has sent its last byte.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pay_nxt       = pay_r;
    left_nxt      = left_r;
    q_pop         = 1'b0;
    if (advance) begin
      if (left_r != 4'd0) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pay_r[63:56];
        out_last_nxt  = (left_r == 4'd1);
        pay_nxt       = {pay_r[55:0], 8'h00};
        left_nxt      = left_r - 4'd1;
      end else if (q_valid) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = q_job.prefix;
        out_last_nxt  = (q_job.nbytes == 4'd0);
        pay_nxt       = q_job.payload;
        left_nxt      = q_job.nbytes;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_r      <= 4'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    pay_r      <= pay_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.last     = out_last_r;
  assign stat.busy         = (left_r != 4'd0);

endmodule

/* hdl/ordered_key_integer_encoder_top.sv */
`timescale 1ns / 1ps
// Order-preserving integer key encoder.
// Each request on in_chan carries an encoding kind and a 64-bit value. The
// block answers with the key as a byte stream on out_chan, prefix byte first,
// with last raised on the final byte. Kind 3 is accepted and dropped.
// A request passes through the front classification register, the queue and
// the output register before its prefix byte leaves. Longer keys follow with
// one byte per cycle while out_chan.ready is high, up to nine bytes.
// Throughput is set by the byte-wide output register: a request occupies it
// for one to nine key bytes, nine in the worst case. The front keeps
// accepting requests while the back is still sending, until the queue
// between them is full and the front register holds a request.
// When the receiver holds out_chan.ready low, the current byte is held, the
// back stops, the queue fills and in_chan.ready then drops.
// Reset (rst_n low at a clock edge) empties the front register, the queue and
// the output register; no partial key survives it.
module ordered_key_integer_encoder_top #(
  parameter int QUEUE_DEPTH = okie_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  okie_in_if.sink    in_chan,
  okie_out_if.source out_chan
);

  logic                 f_valid;
  okie_pkg::job_t       f_job;
  logic                 q_ready;
  logic                 q_valid;
  okie_pkg::job_t       q_job;
  logic                 q_pop;
  okie_pkg::q_stat_t    q_stat;
  okie_pkg::back_stat_t b_stat;

  // Front: classifies each request into prefix, byte count and aligned payload.
  okie_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_ready (q_ready),
    .f_valid (f_valid),
    .f_job   (f_job)
  );

  // Short queue that decouples classification from serialization.
  okie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_job   (f_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (q_job),
    .stat       (q_stat)
  );

  // Back: sends the prefix and then the payload bytes, most significant first.
  okie_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_pop    (q_pop),
    .out_chan (out_chan),
    .stat     (b_stat)
  );

`ifndef SYNTHESIS
  // The queue can never report full and empty at once.
  assert property (@(posedge clk) disable iff (!rst_n) !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  // A byte that is not the last of its key always has payload bytes behind it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.last) |-> b_stat.busy)
    else $error("non-final byte with no payload pending");

  // A held front register and a full queue must stall the input channel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && q_stat.full) |-> !in_chan.ready)
    else $error("input accepted while front and queue are full");

  // Nothing is presented on the output in the cycle after reset.
  assert property (@(posedge clk) $past(!rst_n) |-> !out_chan.valid)
    else $error("output valid right after reset");
`endif

endmodule
